// ===== rtl/core/n2a_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// n2a_pkg
// Shared types, character codes and helpers for the number formatter.
// ---------------------------------------------------------------------------
package n2a_pkg;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned POS_W   = 3;
   localparam int unsigned POW_W   = 14;

   localparam logic [1:0] MODE_BYTE_HEX = 2'd0;
   localparam logic [1:0] MODE_WORD_HEX = 2'd1;
   localparam logic [1:0] MODE_BYTE_DEC = 2'd2;
   localparam logic [1:0] MODE_WORD_DEC = 2'd3;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_ALPHA = 7'd55;
   localparam logic [CHAR_W-1:0] ASCII_LF    = 7'd10;
   localparam logic [CHAR_W-1:0] ASCII_CR    = 7'd13;
   localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'd32;

   // index of the units position in the decimal power table
   localparam logic [POS_W-1:0] POW_UNITS_IDX = 3'd4;

   typedef struct packed {
      logic                 is_dec;
      logic [VALUE_W-1:0]   work;      // hex: shift word, dec: remainder
      logic [POS_W-1:0]     ndig;      // number of digit characters
      logic [POS_W-1:0]     last_idx;  // position of the final character
      logic [POS_W-1:0]     pidx;      // first decimal power index
   } job_type;

   function automatic logic [POW_W-1:0] pow10(input logic [POS_W-1:0] idx);
      logic [POW_W-1:0] p;
      unique case (idx)
         3'd0:    p = 14'd10000;
         3'd1:    p = 14'd1000;
         3'd2:    p = 14'd100;
         3'd3:    p = 14'd10;
         default: p = 14'd1;
      endcase
      return p;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = ASCII_ZERO + {3'b000, nib};
      end else begin
         c = ASCII_ALPHA + {3'b000, nib};
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/number_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps
// path: queue entry, then sequencer registers, then output register, then rsp
// throughput: one character per cycle if rsp does not stall, 2 to 7 per request
//   (digits plus optional LF/CR), set by the single-character output register
// a two-entry job queue lets requests be taken while the back part is busy
// reset: synchronous, active high; clears queue, sequencer and output valid
// ---------------------------------------------------------------------------
// number_to_ascii_formatter_core
// Formats a 16-bit number as hex or decimal ASCII, one character per transfer.
// ---------------------------------------------------------------------------
module number_to_ascii_formatter_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [15:0]  req_value,
   input  logic [1:0]   req_mode,
   input  logic         req_add_newline,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [6:0]   rsp_char_out,
   output logic         rsp_last_char
);
   import n2a_pkg::*;

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_not_empty;
   job_type  push_job;
   job_type  head_job;

   n2a_front u_front (
      .req_valid       (req_valid),
      .req_value       (req_value),
      .req_mode        (req_mode),
      .req_add_newline (req_add_newline),
      .queue_full      (queue_full),
      .req_stall       (req_stall),
      .push            (push),
      .push_job        (push_job)
   );

   n2a_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   n2a_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_avail     (queue_not_empty),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ===== rtl/core/n2a_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// n2a_front
// Accepts request transfers and turns each into a job descriptor.
// ---------------------------------------------------------------------------
module n2a_front (
   input  logic                  req_valid,
   input  logic [15:0]           req_value,
   input  logic [1:0]            req_mode,
   input  logic                  req_add_newline,
   input  logic                  queue_full,
   output logic                  req_stall,
   output logic                  push,
   output n2a_pkg::job_type      push_job
);
   import n2a_pkg::*;

   logic [POS_W-1:0] nl_extra;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign nl_extra  = req_add_newline ? 3'd2 : 3'd0;

   always_comb begin
      push_job = '0;
      unique case (req_mode)
         MODE_BYTE_HEX: begin
            push_job.is_dec = 1'b0;
            push_job.work   = {req_value[7:0], 8'h00};
            push_job.ndig   = 3'd2;
            push_job.pidx   = 3'd0;
         end
         MODE_WORD_HEX: begin
            push_job.is_dec = 1'b0;
            push_job.work   = req_value;
            push_job.ndig   = 3'd4;
            push_job.pidx   = 3'd0;
         end
         MODE_BYTE_DEC: begin
            push_job.is_dec = 1'b1;
            push_job.work   = {8'h00, req_value[7:0]};
            push_job.ndig   = 3'd3;
            push_job.pidx   = 3'd2;
         end
         MODE_WORD_DEC: begin
            push_job.is_dec = 1'b1;
            push_job.work   = req_value;
            push_job.ndig   = 3'd5;
            push_job.pidx   = 3'd0;
         end
      endcase
      push_job.last_idx = push_job.ndig - 3'd1 + nl_extra;
   end

endmodule

// ===== rtl/core/n2a_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// n2a_queue
// Two-entry job queue between the front and back parts.
// ---------------------------------------------------------------------------
module n2a_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  n2a_pkg::job_type      push_job,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output n2a_pkg::job_type      head_job
);
   import n2a_pkg::*;

   job_type     entries_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/n2a_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// n2a_back
// Character sequencer: emits one character of the current job per cycle while rsp is not stalled.
// ---------------------------------------------------------------------------
module n2a_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_avail,
   input  n2a_pkg::job_type      head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [6:0]            rsp_char_out,
   output logic                  rsp_last_char
);
   import n2a_pkg::*;

   logic                busy_ff, busy_in;
   logic                is_dec_ff;
   logic [VALUE_W-1:0]  work_ff;
   logic [POS_W-1:0]    ndig_ff;
   logic [POS_W-1:0]    last_idx_ff;
   logic [POS_W-1:0]    pidx_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                seen_ff;
   logic                out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]   out_char_ff;
   logic                out_last_ff;

   logic                out_free;
   logic                emit;
   logic                is_last;
   logic                in_digits;
   logic [POW_W-1:0]    pow_val;
   logic [3:0]          dgt;
   logic [VALUE_W-1:0]  dec_sub;
   logic [CHAR_W-1:0]   char_sel;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign is_last   = (pos_ff == last_idx_ff);
   assign in_digits = (pos_ff < ndig_ff);
   assign pop       = job_avail && (!busy_ff || (emit && is_last));

   // decimal digit by parallel compare against the multiples of the power
   always_comb begin
      pow_val = pow10(pidx_ff);
      dgt     = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, work_ff} >= 17'(k) * {3'b000, pow_val}) begin
            dgt = 4'(k);
         end
      end
      // digit times power never exceeds the remainder, so this fits
      dec_sub = work_ff - (VALUE_W'(dgt) * VALUE_W'(pow_val));
   end

   always_comb begin
      priority if (in_digits) begin
         if (!is_dec_ff) begin
            char_sel = hex_char(work_ff[15:12]);
         end else if (seen_ff || dgt != 4'd0 || pidx_ff == POW_UNITS_IDX) begin
            char_sel = ASCII_ZERO + {3'b000, dgt};
         end else begin
            char_sel = ASCII_SPACE;
         end
      end else if (pos_ff == ndig_ff) begin
         char_sel = ASCII_LF;
      end else begin
         char_sel = ASCII_CR;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (pop) begin
         busy_in = 1'b1;
      end else if (emit && is_last) begin
         busy_in = 1'b0;
      end
      out_valid_in = out_free ? emit : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         is_dec_ff   <= head_job.is_dec;
         work_ff     <= head_job.work;
         ndig_ff     <= head_job.ndig;
         last_idx_ff <= head_job.last_idx;
         pidx_ff     <= head_job.pidx;
         pos_ff      <= '0;
         seen_ff     <= 1'b0;
      end else if (emit) begin
         pos_ff <= pos_ff + 3'd1;
         if (in_digits) begin
            if (is_dec_ff) begin
               work_ff <= dec_sub;
               pidx_ff <= pidx_ff + 3'd1;
               seen_ff <= seen_ff || (dgt != 4'd0);
            end else begin
               work_ff <= {work_ff[11:0], 4'h0};
            end
         end
      end
      if (emit) begin
         out_char_ff <= char_sel;
         out_last_ff <= is_last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_char_out  = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

// ===== test/tb_number_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_number_to_ascii_formatter_core
// Drives numbers in all four formats through the formatter with random
// sender gaps and receiver stalls. One long receiver hold fills the core up.
// A scoreboard predicts every character and last mark and checks them in
// order against the rsp transfers.
// ---------------------------------------------------------------------------
module tb_number_to_ascii_formatter_core;
   import n2a_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned LONG_HOLD    = 150;
   localparam int unsigned DRAIN_CYCLES = 16;

   class n2a_scoreboard;
      typedef struct packed {
         logic [CHAR_W-1:0] ch;
         logic              last;
      } char_rec_type;

      char_rec_type expected_chars[$];
      int unsigned  errors;

      function void note_request(input logic [15:0] value, input logic [1:0] mode,
                                 input logic add_nl);
         logic [CHAR_W-1:0] text[$];
         logic [3:0]        nib;
         int unsigned       num;
         int unsigned       ndig;
         int unsigned       div;
         int unsigned       dgt;
         int unsigned       i;
         bit                seen;
         char_rec_type      rec;
         case (mode)
            MODE_BYTE_HEX, MODE_WORD_HEX: begin
               ndig = (mode == MODE_BYTE_HEX) ? 2 : 4;
               for (i = 0; i < ndig; i++) begin
                  nib = 4'(value >> (4 * (ndig - 1 - i)));
                  text.push_back(nib < 10 ? ASCII_ZERO + 7'(nib) : ASCII_ALPHA + 7'(nib));
               end
            end
            default: begin
               num  = (mode == MODE_BYTE_DEC) ? {8'h00, value[7:0]} : value;
               ndig = (mode == MODE_BYTE_DEC) ? 3 : 5;
               div  = 1;
               for (i = 1; i < ndig; i++) div *= 10;
               seen = 1'b0;
               // leading zeros become blanks, the units digit always shows
               for (i = 0; i < ndig; i++) begin
                  dgt = (num / div) % 10;
                  if (dgt != 0) seen = 1'b1;
                  text.push_back((seen || div == 1) ? ASCII_ZERO + 7'(dgt) : ASCII_SPACE);
                  div /= 10;
               end
            end
         endcase
         if (add_nl) begin
            text.push_back(ASCII_LF);
            text.push_back(ASCII_CR);
         end
         foreach (text[k]) begin
            rec.ch   = text[k];
            rec.last = (k == text.size() - 1);
            expected_chars.push_back(rec);
         end
      endfunction

      function void check_char(input logic [CHAR_W-1:0] ch, input logic last);
         char_rec_type rec;
         if (expected_chars.size() == 0) begin
            $error("unexpected rsp transfer: char_out %0d last_char %0d", ch, last);
            errors++;
         end else begin
            rec = expected_chars.pop_front();
            if (ch !== rec.ch) begin
               $error("char_out mismatch: expected %0d, actual %0d", rec.ch, ch);
               errors++;
            end
            if (last !== rec.last) begin
               $error("last_char mismatch: expected %0d, actual %0d", rec.last, last);
               errors++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_chars.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [15:0]        req_value;
   logic [1:0]         req_mode;
   logic               req_add_newline;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CHAR_W-1:0]  rsp_char_out;
   logic               rsp_last_char;

   n2a_scoreboard      sb;
   int unsigned        req_idle_pct;
   int unsigned        rsp_idle_pct;
   bit                 long_hold_req;
   int unsigned        cycle_count;

   number_to_ascii_formatter_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_mode        (req_mode),
      .req_add_newline (req_add_newline),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_char   (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[number_to_ascii_formatter_core] ERROR");
      $finish;
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            for (hold = 0; hold < LONG_HOLD; hold++) @(negedge clock);
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_char(rsp_char_out, rsp_last_char);
   end

   task automatic send_request(input logic [15:0] value, input logic [1:0] mode,
                               input logic add_nl);
      @(negedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= value;
      req_mode        <= mode;
      req_add_newline <= add_nl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(value, mode, add_nl);
   endtask

   // values biased toward digit-count boundaries and the ends of the range
   function automatic logic [15:0] pick_value();
      int unsigned edges[12] = '{9, 10, 99, 100, 255, 256, 999, 1000, 9999, 10000,
                                 32768, 65535};
      case ($urandom_range(5))
         0:       return 16'($urandom_range(0, 20));
         1:       return 16'(edges[$urandom_range(11)]);
         2:       return 16'($urandom_range(65515, 65535));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random(input int unsigned count);
      repeat (count) begin
         send_request(pick_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      sb              = new();
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      long_hold_req   = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_mode        = MODE_BYTE_HEX;
      req_add_newline = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: range ends, every mode, high byte ignored, zero in decimal
      send_request(16'h0000, MODE_BYTE_HEX, 1'b0);
      send_request(16'hFFFF, MODE_BYTE_HEX, 1'b1);
      send_request(16'h12A5, MODE_BYTE_HEX, 1'b0);
      send_request(16'h0000, MODE_WORD_HEX, 1'b1);
      send_request(16'hFFFF, MODE_WORD_HEX, 1'b0);
      send_request(16'h9ABC, MODE_WORD_HEX, 1'b1);
      send_request(16'h5A3F, MODE_WORD_HEX, 1'b0);
      send_request(16'd0,    MODE_BYTE_DEC, 1'b0);
      send_request(16'hFF00, MODE_BYTE_DEC, 1'b1);
      send_request(16'd255,  MODE_BYTE_DEC, 1'b0);
      send_request(16'd9,    MODE_BYTE_DEC, 1'b1);
      send_request(16'd10,   MODE_BYTE_DEC, 1'b0);
      send_request(16'h0164, MODE_BYTE_DEC, 1'b1);
      send_request(16'd0,    MODE_WORD_DEC, 1'b1);
      send_request(16'd65535, MODE_WORD_DEC, 1'b1);
      send_request(16'd9,    MODE_WORD_DEC, 1'b0);
      send_request(16'd10,   MODE_WORD_DEC, 1'b0);
      send_request(16'd10000, MODE_WORD_DEC, 1'b0);
      send_request(16'd1005, MODE_WORD_DEC, 1'b1);

      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_random(150);

      // receiver holds off while the sender keeps offering
      req_idle_pct  = 0;
      long_hold_req = 1'b1;
      send_random(100);

      req_idle_pct = 50;
      rsp_idle_pct = 50;
      send_random(150);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(100);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[number_to_ascii_formatter_core] OK");
      end else begin
         $display("[number_to_ascii_formatter_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== number_to_ascii_formatter_core.f =====
rtl/core/n2a_pkg.sv
rtl/core/n2a_front.sv
rtl/core/n2a_queue.sv
rtl/core/n2a_back.sv
rtl/core/number_to_ascii_formatter_core.sv
test/tb_number_to_ascii_formatter_core.sv
